FILE: design/dst_pkg.sv
// Shared types and constants of the descriptor slot table.
package dst_pkg;

    localparam int NUM_SLOTS       = 16;
    localparam int FIRST_FREE_SLOT = 3;
    localparam int STD_SLOTS       = 3;

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int STD_W = $clog2(STD_SLOTS);

    localparam int HANDLE_W = 32;
    localparam int SLOT_W   = 8;

    localparam logic [NUM_SLOTS-1:0] STD_MASK = NUM_SLOTS'((2 ** STD_SLOTS) - 1);

    typedef enum logic [2:0] {
        ACT_BIND     = 3'd0,
        ACT_ALLOC    = 3'd1,
        ACT_GET      = 3'd2,
        ACT_RETAIN   = 3'd3,
        ACT_CLOSE    = 3'd4,
        ACT_OWNED    = 3'd5,
        ACT_TEARDOWN = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_NOFREE   = 3'd3,
        ST_SHUT     = 3'd4
    } status_t;

    typedef struct packed {
        action_t               action;
        logic [SLOT_W-1:0]     slot;
        logic [HANDLE_W-1:0]   handle_in;
    } req_item_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_W-1:0]     slot_out;
        logic [HANDLE_W-1:0]   handle_out;
        logic                  close_request;
        logic                  retain_request;
        logic                  flag;
        logic                  last;
    } rsp_item_t;

endpackage

FILE: design/dst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module dst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/descriptor_slot_table_unit.sv
// Top level of the descriptor slot table: sequencer, slot marks and handle RAM.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  req     | in        | req_valid / req_ready | dst_pkg::req_item_t
//  rsp     | out       | rsp_valid / rsp_ready | dst_pkg::rsp_item_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data, null handle
//
// Range and shut-down errors and the owned query answer in the cycle after the item
// is taken; bind, get and close pass through the read state for the handle RAM read.
// Allocate scans one slot a cycle from the first free slot. Teardown walks the slots
// in order up to the last one in use, one a cycle while the output register is free,
// and passes through an emit state per handle; each handle waits for the one before.
// No clearing pass follows reset; a new item is taken only once the previous
// results have all left the output register, which holds while rsp_ready is low.
module descriptor_slot_table_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  dst_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dst_pkg::rsp_item_t  rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [31:0]         cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_TEAR,
        S_TEMIT
    } state_t;

    state_t                              state_reg, state_next;
    dst_pkg::action_t                    act_reg, act_next;
    logic [dst_pkg::CNT_W-1:0]           idx_reg, idx_next;
    logic [dst_pkg::HANDLE_W-1:0]        hold_reg, hold_next;
    logic [dst_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [dst_pkg::NUM_SLOTS-1:0]       in_use_reg, in_use_next;
    logic [dst_pkg::NUM_SLOTS-1:0]       ever_reg, ever_next;
    logic [dst_pkg::STD_SLOTS-1:0]       holds_reset_reg, holds_reset_next;
    logic                                shut_reg, shut_next;
    logic [dst_pkg::HANDLE_W-1:0]        null_reg, null_next;
    dst_pkg::rsp_item_t                  rsp_reg, rsp_next;
    logic                                rsp_valid_reg, rsp_valid_next;

    logic                                ram_we;
    logic [dst_pkg::IDX_W-1:0]           ram_raddr;
    logic [dst_pkg::HANDLE_W-1:0]        ram_rdata;
    logic [dst_pkg::IDX_W-1:0]           sidx;
    logic [dst_pkg::IDX_W-1:0]           req_idx;
    logic                                in_range;
    logic [dst_pkg::HANDLE_W-1:0]        handle_rd;

    function automatic dst_pkg::rsp_item_t make_rsp(
        input dst_pkg::status_t           st,
        input logic [dst_pkg::SLOT_W-1:0] so,
        input logic [dst_pkg::HANDLE_W-1:0] h,
        input logic                       cr,
        input logic                       rr,
        input logic                       fl,
        input logic                       la
    );
        dst_pkg::rsp_item_t r;
        r.status         = st;
        r.slot_out       = so;
        r.handle_out     = h;
        r.close_request  = cr;
        r.retain_request = rr;
        r.flag           = fl;
        r.last           = la;
        return r;
    endfunction

    assign sidx     = idx_reg[dst_pkg::IDX_W-1:0];
    assign req_idx  = req.slot[dst_pkg::IDX_W-1:0];
    assign in_range = req.slot < dst_pkg::SLOT_W'(dst_pkg::NUM_SLOTS);

    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The first slots read as the null handle until something is stored in them.
    assign handle_rd = (sidx < dst_pkg::IDX_W'(dst_pkg::STD_SLOTS)
                        && holds_reset_reg[sidx[dst_pkg::STD_W-1:0]])
                       ? null_reg : ram_rdata;

    assign ram_raddr = (state_reg == S_IDLE) ? req_idx : sidx;

    dst_ram #(
        .WIDTH (dst_pkg::HANDLE_W),
        .DEPTH (dst_pkg::NUM_SLOTS)
    ) u_handles (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sidx),
        .wdata (hold_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        idx_next         = idx_reg;
        hold_next        = hold_reg;
        count_next       = count_reg;
        in_use_next      = in_use_reg;
        ever_next        = ever_reg;
        holds_reset_next = holds_reset_reg;
        shut_next        = shut_reg;
        null_next        = null_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        ram_we           = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            null_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    act_next  = req.action;
                    idx_next  = dst_pkg::CNT_W'(req_idx);
                    hold_next = req.handle_in;
                    unique case (req.action)
                        dst_pkg::ACT_BIND, dst_pkg::ACT_GET, dst_pkg::ACT_RETAIN:
                        begin
                            if (!in_range)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_RANGE, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else if (shut_reg)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_SHUT, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        dst_pkg::ACT_CLOSE:
                        begin
                            if (!in_range)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_NOTFOUND, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else if (shut_reg)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_SHUT, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        dst_pkg::ACT_OWNED:
                        begin
                            if (!in_range)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_RANGE, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_OK, '0, '0, 1'b0, 1'b0,
                                                    in_use_reg[req_idx] | ever_reg[req_idx],
                                                    1'b1);
                            end
                            rsp_valid_next = 1'b1;
                        end
                        dst_pkg::ACT_ALLOC:
                        begin
                            if (shut_reg)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_SHUT, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                idx_next   = dst_pkg::CNT_W'(dst_pkg::FIRST_FREE_SLOT);
                                state_next = S_SCAN;
                            end
                        end
                        dst_pkg::ACT_TEARDOWN:
                        begin
                            if (shut_reg)
                            begin
                                rsp_next = make_rsp(dst_pkg::ST_SHUT, '0, '0,
                                                    1'b0, 1'b0, 1'b0, 1'b1);
                                rsp_valid_next = 1'b1;
                            end
                            else
                            begin
                                shut_next = 1'b1;
                                if (count_reg == '0)
                                begin
                                    rsp_next = make_rsp(dst_pkg::ST_OK, '0, '0,
                                                        1'b0, 1'b0, 1'b0, 1'b1);
                                    rsp_valid_next = 1'b1;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = S_TEAR;
                                end
                            end
                        end
                        default:
                        begin
                            // The undefined action is dropped without a result.
                        end
                    endcase
                end
            end

            S_READ:
            begin
                rsp_valid_next = 1'b1;
                state_next     = S_IDLE;
                unique case (act_reg)
                    dst_pkg::ACT_BIND:
                    begin
                        if (in_use_reg[sidx])
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_OK, '0, handle_rd,
                                                1'b1, 1'b0, 1'b0, 1'b1);
                        end
                        else
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_OK, '0, '0,
                                                1'b0, 1'b0, 1'b0, 1'b1);
                            count_next = count_reg + 1'b1;
                        end
                        ram_we            = 1'b1;
                        in_use_next[sidx] = 1'b1;
                        ever_next[sidx]   = 1'b1;
                        if (sidx < dst_pkg::IDX_W'(dst_pkg::STD_SLOTS))
                        begin
                            holds_reset_next[sidx[dst_pkg::STD_W-1:0]] = 1'b0;
                        end
                    end
                    dst_pkg::ACT_GET, dst_pkg::ACT_RETAIN:
                    begin
                        if (in_use_reg[sidx])
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_OK, '0, handle_rd, 1'b0,
                                                act_reg == dst_pkg::ACT_RETAIN,
                                                1'b1, 1'b1);
                        end
                        else
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_NOTFOUND, '0, '0,
                                                1'b0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                    default:
                    begin
                        // Close is the only other action that reaches this state.
                        if (in_use_reg[sidx])
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_OK, '0, handle_rd,
                                                1'b1, 1'b0, 1'b0, 1'b1);
                            in_use_next[sidx] = 1'b0;
                            count_next        = count_reg - 1'b1;
                        end
                        else
                        begin
                            rsp_next = make_rsp(dst_pkg::ST_NOTFOUND, '0, '0,
                                                1'b0, 1'b0, 1'b0, 1'b1);
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                if (idx_reg == dst_pkg::CNT_W'(dst_pkg::NUM_SLOTS))
                begin
                    rsp_next = make_rsp(dst_pkg::ST_NOFREE, '0, '0,
                                        1'b0, 1'b0, 1'b0, 1'b1);
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (!in_use_reg[sidx])
                begin
                    rsp_next = make_rsp(dst_pkg::ST_OK, dst_pkg::SLOT_W'(idx_reg), '0,
                                        1'b0, 1'b0, 1'b0, 1'b1);
                    rsp_valid_next    = 1'b1;
                    ram_we            = 1'b1;
                    in_use_next[sidx] = 1'b1;
                    ever_next[sidx]   = 1'b1;
                    count_next        = count_reg + 1'b1;
                    if (sidx < dst_pkg::IDX_W'(dst_pkg::STD_SLOTS))
                    begin
                        holds_reset_next[sidx[dst_pkg::STD_W-1:0]] = 1'b0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TEAR:
            begin
                // Move on only when the output register will be free for the next item.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    if (in_use_reg[sidx])
                    begin
                        state_next = S_TEMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            S_TEMIT:
            begin
                rsp_next = make_rsp(dst_pkg::ST_OK, dst_pkg::SLOT_W'(idx_reg), handle_rd,
                                    1'b1, 1'b0, 1'b0,
                                    count_reg == dst_pkg::CNT_W'(1));
                rsp_valid_next    = 1'b1;
                in_use_next[sidx] = 1'b0;
                count_next        = count_reg - 1'b1;
                idx_next          = idx_reg + 1'b1;
                state_next        = (count_reg == dst_pkg::CNT_W'(1)) ? S_IDLE : S_TEAR;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            act_reg         <= dst_pkg::ACT_BIND;
            idx_reg         <= '0;
            hold_reg        <= '0;
            count_reg       <= dst_pkg::CNT_W'(dst_pkg::STD_SLOTS);
            in_use_reg      <= dst_pkg::STD_MASK;
            ever_reg        <= dst_pkg::STD_MASK;
            holds_reset_reg <= '1;
            shut_reg        <= 1'b0;
            null_reg        <= '0;
            rsp_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            act_reg         <= act_next;
            idx_reg         <= idx_next;
            hold_reg        <= hold_next;
            count_reg       <= count_next;
            in_use_reg      <= in_use_next;
            ever_reg        <= ever_next;
            holds_reset_reg <= holds_reset_next;
            shut_reg        <= shut_next;
            null_reg        <= null_next;
            rsp_reg         <= rsp_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

endmodule

FILE: sim/descriptor_slot_table_unit_tb.sv
// Self-checking testbench of the descriptor slot table with a slot-table predictor.
`timescale 1ns / 1ps

module descriptor_slot_table_unit_tb;
    import dst_pkg::*;

    localparam logic [2:0] ACT_UNDEFINED = 3'd7;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 100;

    // Mirror of the slot table: handles, marks, shut-down flag and null handle.
    class slot_table_scoreboard;
        logic [HANDLE_W-1:0] handles [NUM_SLOTS];
        bit                  in_use [NUM_SLOTS];
        bit                  was_used [NUM_SLOTS];
        bit                  pristine [STD_SLOTS];
        bit                  shut;
        logic [HANDLE_W-1:0] null_value;
        rsp_item_t           expected_rsp [$];
        int                  errors;

        function new();
            null_value = '0;
            shut       = 1'b0;
            errors     = 0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                handles[i]  = '0;
                in_use[i]   = (i < STD_SLOTS);
                was_used[i] = (i < STD_SLOTS);
            end
            for (int i = 0; i < STD_SLOTS; i++)
                pristine[i] = 1'b1;
        endfunction

        function void write_null(logic [HANDLE_W-1:0] value);
            null_value = value;
            for (int i = 0; i < STD_SLOTS; i++)
                if (pristine[i])
                    handles[i] = value;
        endfunction

        function void push(status_t st, int slot_out, logic [HANDLE_W-1:0] h,
                           bit close_req, bit retain_req, bit flag, bit last);
            rsp_item_t r;
            r.status         = st;
            r.slot_out       = SLOT_W'(slot_out);
            r.handle_out     = h;
            r.close_request  = close_req;
            r.retain_request = retain_req;
            r.flag           = flag;
            r.last           = last;
            expected_rsp.push_back(r);
        endfunction

        function void store(int s, logic [HANDLE_W-1:0] h);
            handles[s]  = h;
            in_use[s]   = 1'b1;
            was_used[s] = 1'b1;
            if (s < STD_SLOTS)
                pristine[s] = 1'b0;
        endfunction

        function void note_request(req_item_t it);
            int  s;
            int  emitted;
            bit  in_range;
            bit  placed;
            s        = int'(it.slot);
            in_range = (s < NUM_SLOTS);
            case (it.action)
                ACT_BIND:
                begin
                    if (!in_range)
                        push(ST_RANGE, 0, '0, 0, 0, 0, 1);
                    else if (shut)
                        push(ST_SHUT, 0, '0, 0, 0, 0, 1);
                    else if (in_use[s])
                    begin
                        push(ST_OK, 0, handles[s], 1, 0, 0, 1);
                        store(s, it.handle_in);
                    end
                    else
                    begin
                        push(ST_OK, 0, '0, 0, 0, 0, 1);
                        store(s, it.handle_in);
                    end
                end
                ACT_ALLOC:
                begin
                    placed = 1'b0;
                    if (shut)
                        push(ST_SHUT, 0, '0, 0, 0, 0, 1);
                    else
                    begin
                        for (int i = FIRST_FREE_SLOT; i < NUM_SLOTS && !placed; i++)
                        begin
                            if (!in_use[i])
                            begin
                                store(i, it.handle_in);
                                push(ST_OK, i, '0, 0, 0, 0, 1);
                                placed = 1'b1;
                            end
                        end
                        if (!placed)
                            push(ST_NOFREE, 0, '0, 0, 0, 0, 1);
                    end
                end
                ACT_GET, ACT_RETAIN:
                begin
                    if (!in_range)
                        push(ST_RANGE, 0, '0, 0, 0, 0, 1);
                    else if (shut)
                        push(ST_SHUT, 0, '0, 0, 0, 0, 1);
                    else if (in_use[s])
                        push(ST_OK, 0, handles[s], 0, it.action == ACT_RETAIN, 1, 1);
                    else
                        push(ST_NOTFOUND, 0, '0, 0, 0, 0, 1);
                end
                ACT_CLOSE:
                begin
                    if (!in_range)
                        push(ST_NOTFOUND, 0, '0, 0, 0, 0, 1);
                    else if (shut)
                        push(ST_SHUT, 0, '0, 0, 0, 0, 1);
                    else if (in_use[s])
                    begin
                        in_use[s] = 1'b0;
                        push(ST_OK, 0, handles[s], 1, 0, 0, 1);
                    end
                    else
                        push(ST_NOTFOUND, 0, '0, 0, 0, 0, 1);
                end
                ACT_OWNED:
                begin
                    if (!in_range)
                        push(ST_RANGE, 0, '0, 0, 0, 0, 1);
                    else
                        push(ST_OK, 0, '0, 0, 0, in_use[s] || was_used[s], 1);
                end
                ACT_TEARDOWN:
                begin
                    if (shut)
                        push(ST_SHUT, 0, '0, 0, 0, 0, 1);
                    else
                    begin
                        shut    = 1'b1;
                        emitted = 0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (in_use[i])
                            begin
                                in_use[i] = 1'b0;
                                push(ST_OK, i, handles[i], 1, 0, 0, 0);
                                emitted++;
                            end
                        end
                        if (emitted == 0)
                            push(ST_OK, 0, '0, 0, 0, 0, 1);
                        else
                            expected_rsp[expected_rsp.size() - 1].last = 1'b1;
                    end
                end
                default:
                    ;
            endcase
        endfunction

        function void compare_field(string name, logic [HANDLE_W-1:0] want,
                                    logic [HANDLE_W-1:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rsp_item_t got);
            rsp_item_t want;
            if (expected_rsp.size() == 0)
            begin
                $error("result item arrived with none expected");
                errors++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
            compare_field("handle_out", want.handle_out, got.handle_out);
            compare_field("close_request", 32'(want.close_request), 32'(got.close_request));
            compare_field("retain_request", 32'(want.retain_request),
                          32'(got.retain_request));
            compare_field("flag", 32'(want.flag), 32'(got.flag));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         req_valid;
    logic         req_ready;
    req_item_t    req;
    logic         rsp_valid;
    logic         rsp_ready;
    rsp_item_t    rsp;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    slot_table_scoreboard sb;
    int  results_seen;
    bit  no_idle;
    int  hold_left;
    bit  hold_done;
    bit  empty_teardown;

    descriptor_slot_table_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Requests are noted before results are checked, so an answer in the same
    // cycle still finds its expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
            begin
                sb.check_result(rsp);
                results_seen++;
            end
        end
    end

    // Result sink: random stalls, plus one long hold-off that lets the table back up.
    initial
    begin
        rsp_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= 40)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= no_idle || ($urandom_range(0, 99) >= 10);
        end
    end

    initial
    begin
        #2_000_000;
        $display("[descriptor_slot_table_unit] ERROR");
        $finish;
    end

    function automatic req_item_t make_request(logic [2:0] act, int s,
                                               logic [HANDLE_W-1:0] h);
        req_item_t it;
        it.action    = action_t'(act);
        it.slot      = SLOT_W'(s);
        it.handle_in = h;
        return it;
    endfunction

    function automatic req_item_t random_request(int alloc_weight, bit allow_teardown);
        logic [2:0]          act;
        int                  s;
        logic [HANDLE_W-1:0] h;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            act = ACT_UNDEFINED;
        else if (allow_teardown && pick < 8)
            act = ACT_TEARDOWN;
        else if ($urandom_range(0, 99) < alloc_weight)
            act = ACT_ALLOC;
        else
        begin
            case ($urandom_range(0, 4))
                0:       act = ACT_BIND;
                1:       act = ACT_GET;
                2:       act = ACT_RETAIN;
                3:       act = ACT_CLOSE;
                default: act = ACT_OWNED;
            endcase
        end
        if ($urandom_range(0, 99) < 85)
            s = $urandom_range(0, NUM_SLOTS - 1);
        else
            s = $urandom_range(NUM_SLOTS, 255);
        case ($urandom_range(0, 19))
            0:       h = '0;
            1:       h = '1;
            default: h = $urandom();
        endcase
        return make_request(act, s, h);
    endfunction

    task automatic offer_request(req_item_t it);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 10)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Undefined actions leave nothing to wait for, so a quiet spell follows the drain.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_null_handle(logic [31:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_null(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, int alloc_weight, bit allow_teardown);
        for (int i = 0; i < count; i++)
            offer_request(random_request(alloc_weight, allow_teardown));
    endtask

    initial
    begin
        sb           = new();
        results_seen = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        write_null_handle(32'hFFFF_FFFF);

        // Reset handles, range errors, displacement, allocation order and reuse.
        offer_request(make_request(ACT_GET, 0, '0));
        offer_request(make_request(ACT_RETAIN, 2, '0));
        offer_request(make_request(ACT_OWNED, 1, '0));
        offer_request(make_request(ACT_OWNED, 9, '0));
        offer_request(make_request(ACT_GET, 9, '0));
        offer_request(make_request(ACT_CLOSE, 9, '0));
        offer_request(make_request(ACT_BIND, NUM_SLOTS, 32'h1111_2222));
        offer_request(make_request(ACT_GET, 255, '0));
        offer_request(make_request(ACT_RETAIN, 128, '0));
        offer_request(make_request(ACT_OWNED, 255, '0));
        offer_request(make_request(ACT_CLOSE, 200, '0));
        offer_request(make_request(ACT_BIND, 1, 32'h0000_0000));
        offer_request(make_request(ACT_BIND, 4, 32'hFFFF_FFFF));
        offer_request(make_request(ACT_ALLOC, 0, 32'h1234_5678));
        offer_request(make_request(ACT_ALLOC, 0, 32'hA5A5_A5A5));
        offer_request(make_request(ACT_CLOSE, 4, '0));
        offer_request(make_request(ACT_OWNED, 4, '0));
        offer_request(make_request(ACT_ALLOC, 0, 32'h5A5A_5A5A));
        offer_request(make_request(ACT_UNDEFINED, 3, 32'hDEAD_BEEF));
        offer_request(make_request(ACT_CLOSE, 1, '0));
        offer_request(make_request(ACT_GET, 1, '0));
        offer_request(make_request(ACT_BIND, NUM_SLOTS - 1, 32'h8000_0001));
        offer_request(make_request(ACT_RETAIN, NUM_SLOTS - 1, '0));
        offer_request(make_request(ACT_CLOSE, 0, '0));
        wait_drained();

        // Slot 2 still holds its reset handle and follows the new null handle.
        write_null_handle(32'h0000_0000);
        offer_request(make_request(ACT_GET, 2, '0));
        run_random(PHASE_ITEMS, 40, 1'b0);
        wait_drained();

        write_null_handle($urandom());
        no_idle = 1'b1;
        run_random(PHASE_ITEMS, 15, 1'b0);
        no_idle = 1'b0;
        wait_drained();

        write_null_handle(32'hFFFF_FFFF);
        run_random(PHASE_ITEMS, 25, 1'b0);

        // Only one teardown can take effect, so the seed picks an empty table
        // now and then, and otherwise a full one for the longest run.
        empty_teardown = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (empty_teardown)
                offer_request(make_request(ACT_CLOSE, i, '0));
            else
                offer_request(make_request(ACT_BIND, i, $urandom()));
        end
        offer_request(make_request(ACT_TEARDOWN, 0, '0));
        offer_request(make_request(ACT_TEARDOWN, 0, '0));
        run_random(30, 20, 1'b1);
        wait_drained();

        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("[descriptor_slot_table_unit] OK");
        else
            $display("[descriptor_slot_table_unit] ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/dst_pkg.sv
design/dst_ram.sv
design/descriptor_slot_table_unit.sv
sim/descriptor_slot_table_unit_tb.sv
